FILE: hdl/bsk_pkg.sv
package bsk_pkg;

	localparam int KEY_W = 32;
	localparam int TAG_W = 32;
	localparam int SORT_SIZE_DEF = 64;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0]        tag;
		logic                    last;
	} in_item_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] sorted_key;
		logic [TAG_W-1:0]        sorted_tag;
		logic                    end_of_run;
		logic                    overflow;
	} out_item_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0]        tag;
	} slot_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key_a;
		logic signed [KEY_W-1:0] key_b;
		logic                    pad_a;
		logic                    pad_b;
		logic                    desc;
	} cmp_req_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_READ,
		ST_CMP,
		ST_WR2,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

endpackage

FILE: hdl/bsk_store.sv
module bsk_store #(
	parameter int AW = 6
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  bsk_pkg::slot_t   wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr_a,
	input  logic [AW-1:0]    rd_addr_b,
	output bsk_pkg::slot_t   rd_data_a,
	output bsk_pkg::slot_t   rd_data_b
);

	localparam int DEPTH = 1 << AW;

	bsk_pkg::slot_t slots_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= slots_q[rd_addr_a];
			rd_data_b <= slots_q[rd_addr_b];
		end
	end

endmodule

FILE: hdl/bsk_cmpx.sv
module bsk_cmpx (
	input  bsk_pkg::cmp_req_t req,
	output logic              swap
);

	logic a_gt_b;
	logic b_gt_a;

	always_comb begin
		if (req.pad_a) begin
			a_gt_b = !req.pad_b;
		end else if (req.pad_b) begin
			a_gt_b = 1'b0;
		end else begin
			a_gt_b = $signed(req.key_a) > $signed(req.key_b);
		end
	end

	always_comb begin
		if (req.pad_b) begin
			b_gt_a = !req.pad_a;
		end else if (req.pad_a) begin
			b_gt_a = 1'b0;
		end else begin
			b_gt_a = $signed(req.key_b) > $signed(req.key_a);
		end
	end

	assign swap = req.desc ? b_gt_a : a_gt_b;

endmodule

FILE: hdl/bitonic_sort_key_tag.sv
// loading: one item per cycle, the item marked last moves the block into sorting
// sorting: log2(N)*(log2(N)+1)/2 stages of N/2 compare-exchanges (N = SORT_SIZE to next power of 2)
// each compare-exchange reads the pair (ST_READ) and compares it (ST_CMP), writing the lower slot
// there on a swap and the upper slot in ST_WR2, all on the one comparator and one store write port
// results: read, then loaded into the output register unless stalled; no new keys until the last is loaded
// reset: asynchronous, empty set, every slot padding, output register empty
module bitonic_sort_key_tag #(
	parameter int SORT_SIZE = bsk_pkg::SORT_SIZE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                key_valid,
	output logic                key_stall,
	input  bsk_pkg::in_item_t   key_item,
	output logic                sorted_valid,
	input  logic                sorted_stall,
	output bsk_pkg::out_item_t  sorted_item
);

	localparam int AW   = (SORT_SIZE > 1) ? $clog2(SORT_SIZE) : 1;
	localparam int N    = 1 << AW;
	localparam int HALF = N / 2;
	localparam int FW   = $clog2(SORT_SIZE + 1);
	localparam int LW   = $clog2(AW + 1);

	bsk_pkg::state_t state_q, state_d;

	logic [FW-1:0] fill_q;
	logic          dropped_q;
	logic [N-1:0]  pad_q;
	logic [AW-1:0] m_q;
	logic [LW-1:0] s_q;
	logic [LW-1:0] t_q;
	logic [FW-1:0] emit_q;
	logic          out_valid_q;
	bsk_pkg::out_item_t out_q;

	logic [AW-1:0] low_mask;
	logic [AW-1:0] idx_i;
	logic [AW-1:0] idx_p;
	logic [AW:0]   dir_bits;
	logic          pair_last;
	logic          stage_last;
	logic          sort_last;
	logic          net_done;
	logic          accept;
	logic          has_room;
	logic          out_free;
	logic          res_last;
	logic          load_out;
	logic          advance;
	logic          swap;

	logic           wr_en;
	logic [AW-1:0]  wr_addr;
	bsk_pkg::slot_t wr_data;
	logic           rd_en;
	logic [AW-1:0]  rd_addr_a;
	logic [AW-1:0]  rd_addr_b;
	bsk_pkg::slot_t rd_a;
	bsk_pkg::slot_t rd_b;
	bsk_pkg::cmp_req_t cmp_req;

	bsk_store #(
		.AW(AW)
	) u_store (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	bsk_cmpx u_cmpx (
		.req  (cmp_req),
		.swap (swap)
	);

	// pair index m with a zero bit inserted at position s gives the lower slot
	always_comb begin
		low_mask = ~({AW{1'b1}} << s_q);
		idx_i    = ((m_q & ~low_mask) << 1) | (m_q & low_mask);
		idx_p    = idx_i | (AW'(1) << s_q);
		dir_bits = {1'b0, idx_i} >> t_q;
	end

	always_comb begin
		cmp_req.key_a = rd_a.key;
		cmp_req.key_b = rd_b.key;
		cmp_req.pad_a = pad_q[idx_i];
		cmp_req.pad_b = pad_q[idx_p];
		cmp_req.desc  = dir_bits[0];
	end

	assign pair_last  = (m_q == AW'(HALF - 1));
	assign stage_last = (s_q == '0);
	assign sort_last  = (t_q == LW'(AW));
	assign net_done   = pair_last && stage_last && sort_last;
	assign accept     = key_valid && !key_stall;
	assign has_room   = (fill_q < FW'(SORT_SIZE));
	assign out_free   = !out_valid_q || !sorted_stall;
	assign res_last   = ((emit_q + FW'(1)) == fill_q);
	assign load_out   = (state_q == bsk_pkg::ST_EMIT_LD) && out_free;
	assign advance    = ((state_q == bsk_pkg::ST_CMP) && !swap) || (state_q == bsk_pkg::ST_WR2);

	always_comb begin
		state_d = state_q;
		case (state_q)
			bsk_pkg::ST_LOAD: begin
				if (accept && key_item.last) begin
					state_d = bsk_pkg::ST_READ;
				end
			end
			bsk_pkg::ST_READ: begin
				state_d = bsk_pkg::ST_CMP;
			end
			bsk_pkg::ST_CMP: begin
				if (swap) begin
					state_d = bsk_pkg::ST_WR2;
				end else if (net_done) begin
					state_d = bsk_pkg::ST_EMIT_RD;
				end else begin
					state_d = bsk_pkg::ST_READ;
				end
			end
			bsk_pkg::ST_WR2: begin
				state_d = net_done ? bsk_pkg::ST_EMIT_RD : bsk_pkg::ST_READ;
			end
			bsk_pkg::ST_EMIT_RD: begin
				state_d = bsk_pkg::ST_EMIT_LD;
			end
			bsk_pkg::ST_EMIT_LD: begin
				if (out_free) begin
					state_d = res_last ? bsk_pkg::ST_LOAD : bsk_pkg::ST_EMIT_RD;
				end
			end
			default: begin
				state_d = bsk_pkg::ST_LOAD;
			end
		endcase
	end

	always_comb begin
		key_stall = 1'b1;
		wr_en     = 1'b0;
		wr_addr   = idx_i;
		wr_data   = rd_b;
		rd_en     = 1'b0;
		rd_addr_a = idx_i;
		rd_addr_b = idx_p;
		case (state_q)
			bsk_pkg::ST_LOAD: begin
				key_stall   = 1'b0;
				wr_en       = key_valid && has_room;
				wr_addr     = fill_q[AW-1:0];
				wr_data.key = key_item.key;
				wr_data.tag = key_item.tag;
			end
			bsk_pkg::ST_READ: begin
				rd_en = 1'b1;
			end
			bsk_pkg::ST_CMP: begin
				wr_en = swap;
			end
			bsk_pkg::ST_WR2: begin
				wr_en   = 1'b1;
				wr_addr = idx_p;
				wr_data = rd_a;
			end
			bsk_pkg::ST_EMIT_RD: begin
				rd_en     = 1'b1;
				rd_addr_a = emit_q[AW-1:0];
				rd_addr_b = emit_q[AW-1:0];
			end
			bsk_pkg::ST_EMIT_LD: begin
				rd_en = 1'b0;
			end
			default: begin
				key_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsk_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			dropped_q <= 1'b0;
			pad_q     <= '1;
		end else if (load_out && res_last) begin
			fill_q    <= '0;
			dropped_q <= 1'b0;
			pad_q     <= '1;
		end else if (accept) begin
			if (has_room) begin
				fill_q                 <= fill_q + FW'(1);
				pad_q[fill_q[AW-1:0]] <= 1'b0;
			end else begin
				dropped_q <= 1'b1;
			end
		end else if ((state_q == bsk_pkg::ST_CMP) && swap) begin
			pad_q[idx_i] <= pad_q[idx_p];
			pad_q[idx_p] <= pad_q[idx_i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= '0;
			s_q <= '0;
			t_q <= LW'(1);
		end else if (accept && key_item.last) begin
			m_q <= '0;
			s_q <= '0;
			t_q <= LW'(1);
		end else if (advance) begin
			m_q <= pair_last ? '0 : m_q + AW'(1);
			if (pair_last) begin
				if (stage_last) begin
					t_q <= t_q + LW'(1);
					s_q <= t_q;
				end else begin
					s_q <= s_q - LW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && key_item.last) begin
				emit_q <= '0;
			end else if (load_out) begin
				emit_q <= emit_q + FW'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!sorted_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.sorted_key <= rd_a.key;
			out_q.sorted_tag <= rd_a.tag;
			out_q.end_of_run <= res_last;
			out_q.overflow   <= dropped_q;
		end
	end

	assign sorted_valid = out_valid_q;
	assign sorted_item  = out_q;

`ifndef NO_ASSERTIONS
	a_last_starts_sort: assert property (@(posedge clk) disable iff (!arst_n)
		accept && key_item.last |=> state_q == bsk_pkg::ST_READ)
		else $error("last transfer did not start the network");

	a_swap_second_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bsk_pkg::ST_CMP) && swap |=> state_q == bsk_pkg::ST_WR2)
		else $error("exchange without second write");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(SORT_SIZE))
		else $error("fill count beyond capacity");

	a_pads_match_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(~pad_q) == int'(fill_q))
		else $error("real slot count differs from fill count");

	a_clear_after_set: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && res_last |=> fill_q == '0 && (&pad_q) && !dropped_q)
		else $error("set not cleared after final transfer");
`endif

endmodule

FILE: test/bitonic_sort_key_tag_tb.sv
`timescale 1ns / 100ps

module bitonic_sort_key_tag_tb;

	localparam int SORT_N = bsk_pkg::SORT_SIZE_DEF;
	localparam int STORE_N = 64;
	localparam int NET_N = 1 << $clog2(SORT_N);
	localparam int DIR_N = 25;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam logic signed [bsk_pkg::KEY_W-1:0] KEY_MIN = 32'h8000_0000;
	localparam logic signed [bsk_pkg::KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;

	typedef struct packed {
		bsk_pkg::in_item_t  item;
		logic               typed;
		bsk_pkg::out_item_t res;
	} stim_row_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                key_valid = 1'b0;
	logic                key_stall;
	bsk_pkg::in_item_t   key_item = '0;
	logic                sorted_valid;
	logic                sorted_stall = 1'b0;
	bsk_pkg::out_item_t  sorted_item;

	logic signed [bsk_pkg::KEY_W-1:0] net_key [STORE_N];
	logic [bsk_pkg::TAG_W-1:0]        net_tag [STORE_N];
	bit                               net_pad [STORE_N];
	int unsigned                      fill_cnt;
	bit                               drop_seen;

	bsk_pkg::out_item_t pending_sorted [$];
	int unsigned        err_count = 0;
	int unsigned        cycle_count = 0;
	int unsigned        results_seen = 0;
	int unsigned        stall_left = 0;
	int unsigned        calm_left = 0;
	bit                 long_hold_done = 1'b0;
	bit                 sender_calm = 1'b0;

	stim_row_t dir_rows [DIR_N] = '{
		'{'{KEY_MIN, 32'h0000_0000, 1'b1}, 1'b1, '{KEY_MIN, 32'h0000_0000, 1'b1, 1'b0}},
		'{'{KEY_MAX, 32'hffff_ffff, 1'b1}, 1'b1, '{KEY_MAX, 32'hffff_ffff, 1'b1, 1'b0}},
		'{'{32'h0000_0000, 32'h0000_0001, 1'b1}, 1'b1,
			'{32'h0000_0000, 32'h0000_0001, 1'b1, 1'b0}},
		'{'{32'hffff_ffff, 32'h8000_0000, 1'b1}, 1'b1,
			'{32'hffff_ffff, 32'h8000_0000, 1'b1, 1'b0}},
		'{'{KEY_MAX, 32'h0000_0010, 1'b0}, 1'b0, '0},
		'{'{KEY_MIN, 32'h0000_0011, 1'b0}, 1'b0, '0},
		'{'{32'hffff_ffff, 32'h0000_0012, 1'b0}, 1'b0, '0},
		'{'{32'h0000_0000, 32'h0000_0013, 1'b1}, 1'b0, '0},
		'{'{32'h0000_0005, 32'h0000_00a1, 1'b0}, 1'b0, '0},
		'{'{32'h0000_0005, 32'h0000_00a2, 1'b0}, 1'b0, '0},
		'{'{32'h0000_0005, 32'h0000_00a3, 1'b0}, 1'b0, '0},
		'{'{32'h0000_0005, 32'h0000_00a4, 1'b1}, 1'b0, '0},
		'{'{32'h0000_0064, 32'h0000_0030, 1'b0}, 1'b0, '0},
		'{'{32'h0000_0032, 32'h0000_0031, 1'b0}, 1'b0, '0},
		'{'{32'hffff_ffce, 32'h0000_0032, 1'b1}, 1'b0, '0},
		'{'{32'h0000_0007, 32'h0000_0040, 1'b0}, 1'b0, '0},
		'{'{32'hffff_fff9, 32'h0000_0041, 1'b1}, 1'b0, '0},
		'{'{32'h1234_5678, 32'h5555_5555, 1'b0}, 1'b0, '0},
		'{'{32'hffff_fc18, 32'haaaa_aaaa, 1'b0}, 1'b0, '0},
		'{'{32'h0000_03e8, 32'h0f0f_0f0f, 1'b0}, 1'b0, '0},
		'{'{KEY_MAX, 32'hf0f0_f0f0, 1'b0}, 1'b0, '0},
		'{'{32'h8000_0001, 32'h0000_ffff, 1'b0}, 1'b0, '0},
		'{'{32'h0000_0000, 32'hffff_0000, 1'b0}, 1'b0, '0},
		'{'{32'h0000_0000, 32'h7fff_fffe, 1'b0}, 1'b0, '0},
		'{'{32'h0000_0002, 32'h0000_0000, 1'b1}, 1'b0, '0}
	};

	bitonic_sort_key_tag i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.key_valid    (key_valid),
		.key_stall    (key_stall),
		.key_item     (key_item),
		.sorted_valid (sorted_valid),
		.sorted_stall (sorted_stall),
		.sorted_item  (sorted_item)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void clear_set();
		for (int i = 0; i < STORE_N; i++) begin
			net_pad[i] = 1'b1;
		end
		fill_cnt = 0;
		drop_seen = 1'b0;
	endfunction

	function automatic bit slot_above(int a, int b);
		if (net_pad[a]) begin
			return !net_pad[b];
		end
		if (net_pad[b]) begin
			return 1'b0;
		end
		return net_key[a] > net_key[b];
	endfunction

	function automatic void swap_slots(int a, int b);
		logic signed [bsk_pkg::KEY_W-1:0] k_tmp;
		logic [bsk_pkg::TAG_W-1:0]        t_tmp;
		bit                               p_tmp;
		k_tmp = net_key[a];
		net_key[a] = net_key[b];
		net_key[b] = k_tmp;
		t_tmp = net_tag[a];
		net_tag[a] = net_tag[b];
		net_tag[b] = t_tmp;
		p_tmp = net_pad[a];
		net_pad[a] = net_pad[b];
		net_pad[b] = p_tmp;
	endfunction

	// store one accepted pair; on a last item sort and queue the whole set
	function automatic void load_and_sort(bsk_pkg::in_item_t it, logic typed,
			bsk_pkg::out_item_t typed_res);
		bsk_pkg::out_item_t res;
		int                 p;
		if (fill_cnt < SORT_N) begin
			net_key[fill_cnt] = it.key;
			net_tag[fill_cnt] = it.tag;
			net_pad[fill_cnt] = 1'b0;
			fill_cnt++;
		end else begin
			drop_seen = 1'b1;
		end
		if (!it.last) begin
			return;
		end
		for (int k = 2; k <= NET_N; k = k << 1) begin
			for (int j = k >> 1; j > 0; j = j >> 1) begin
				for (int i = 0; i < NET_N; i++) begin
					p = i ^ j;
					if (p > i && p < STORE_N) begin
						if ((i & k) == 0) begin
							if (slot_above(i, p)) swap_slots(i, p);
						end else if (slot_above(p, i)) begin
							swap_slots(i, p);
						end
					end
				end
			end
		end
		if (typed) begin
			pending_sorted.push_back(typed_res);
		end else begin
			for (int i = 0; i < fill_cnt; i++) begin
				res.sorted_key = net_key[i];
				res.sorted_tag = net_tag[i];
				res.end_of_run = (i + 1 == fill_cnt);
				res.overflow = drop_seen;
				pending_sorted.push_back(res);
			end
		end
		clear_set();
	endfunction

	task automatic report_error(string what, logic [31:0] got, logic [31:0] want);
		if (err_count < 40) begin
			$display("%0t: mismatch on %s, got %h, expected %h", $time, what, got, want);
		end
		err_count++;
	endtask

	task automatic check_result(bsk_pkg::out_item_t got);
		bsk_pkg::out_item_t want;
		if (pending_sorted.size() == 0) begin
			report_error("unexpected transfer", got.sorted_key, '0);
			return;
		end
		want = pending_sorted.pop_front();
		if (got.sorted_key !== want.sorted_key)
			report_error("sorted_key", got.sorted_key, want.sorted_key);
		if (got.sorted_tag !== want.sorted_tag)
			report_error("sorted_tag", got.sorted_tag, want.sorted_tag);
		if (got.end_of_run !== want.end_of_run)
			report_error("end_of_run", 32'(got.end_of_run), 32'(want.end_of_run));
		if (got.overflow !== want.overflow)
			report_error("overflow", 32'(got.overflow), 32'(want.overflow));
	endtask

	function automatic int unsigned pick_gap();
		int unsigned pick;
		if (sender_calm) begin
			return 0;
		end
		pick = $urandom_range(0, 99);
		if (pick < 65) return 0;
		if (pick < 94) return $urandom_range(1, 3);
		return $urandom_range(15, 60);
	endfunction

	function automatic logic signed [bsk_pkg::KEY_W-1:0] pick_key(int unsigned flavor);
		if (flavor == 1) begin
			return $urandom_range(0, 6) - 3;
		end
		if (flavor == 2) begin
			case ($urandom_range(0, 4))
				0: return KEY_MIN;
				1: return KEY_MAX;
				2: return '0;
				3: return '1;
				default: return $urandom;
			endcase
		end
		return $urandom;
	endfunction

	task automatic send_item(bsk_pkg::in_item_t it, logic typed, bsk_pkg::out_item_t res);
		int unsigned gap;
		key_item <= it;
		key_valid <= 1'b1;
		@(posedge clk);
		while (key_stall) @(posedge clk);
		load_and_sort(it, typed, res);
		gap = pick_gap();
		if (gap != 0) begin
			key_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_set(int unsigned count, int unsigned flavor);
		bsk_pkg::in_item_t it;
		sender_calm = ($urandom_range(0, 3) == 0);
		for (int n = 0; n < count; n++) begin
			it.key = pick_key(flavor);
			it.tag = $urandom;
			it.last = (n == count - 1);
			send_item(it, 1'b0, '0);
		end
	endtask

	task automatic drain_results();
		key_valid <= 1'b0;
		while (pending_sorted.size() != 0) @(posedge clk);
	endtask

	// result side: check each transfer, then pick the next stall
	always @(posedge clk) begin
		int unsigned pick;
		if (arst_n && sorted_valid && !sorted_stall) begin
			check_result(sorted_item);
			results_seen++;
		end
		if (stall_left != 0) begin
			stall_left--;
			sorted_stall <= 1'b1;
		end else if (!long_hold_done && results_seen >= 50) begin
			long_hold_done = 1'b1;
			stall_left = 400;
			sorted_stall <= 1'b1;
		end else if (calm_left != 0) begin
			calm_left--;
			sorted_stall <= 1'b0;
		end else begin
			pick = $urandom_range(0, 199);
			sorted_stall <= 1'b0;
			if (pick < 2)
				calm_left = $urandom_range(50, 300);
			else if (pick < 5)
				stall_left = $urandom_range(15, 60);
			else if (pick < 60)
				stall_left = $urandom_range(1, 3);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int unsigned items;
		int unsigned n;
		int unsigned set_no;
		clear_set();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int r = 0; r < DIR_N; r++) begin
			send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].res);
		end
		drain_results();

		// exactly full store, then three beyond capacity with the last item dropped
		send_set(SORT_N, 0);
		send_set(SORT_N + 3, 2);
		items = 2 * SORT_N + 3;
		set_no = 0;
		while (items < 195) begin
			n = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 10);
			send_set(n, $urandom_range(0, 2));
			items += n;
			set_no++;
			if (set_no == 6) drain_results();
		end
		drain_results();
		repeat (100) @(posedge clk);

		if (pending_sorted.size() != 0)
			report_error("missing transfers", pending_sorted.size(), 0);
		if (err_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
